// ===== sv/rpr_pkg.sv =====
`timescale 1ns / 1ps
package rpr_pkg;

   localparam int P_W      = 16;
   localparam int Q_W      = 16;
   localparam int PF_W     = 12;
   localparam int SP_W     = 7;
   localparam int THR_W    = 8;
   localparam int TP_W     = 10;
   localparam int NUM_W    = 23;   // P * 100
   localparam int DIV_W    = 8;
   localparam int RAD_W    = 2 * NUM_W;
   localparam int ROOT_W   = NUM_W;
   localparam int REM_W    = ROOT_W + 3;
   localparam int KVAR_W   = 16;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [1:0] REG_PF_SETPOINT = 2'd0;
   localparam logic [1:0] REG_DISCONNECT  = 2'd1;
   localparam logic [1:0] REG_TP_RATIO    = 2'd2;

   typedef enum logic [2:0] {
      MODE_ZERO,
      MODE_DIRECT,
      MODE_BAND,
      MODE_SCALE_EXC,
      MODE_SCALE_REQ
   } mode_type;

   typedef struct packed {
      logic [1:0]      phase;
      logic            updated;
      mode_type        mode;
      logic [P_W-1:0]  p;
      logic [Q_W-1:0]  q;
      logic [TP_W-1:0] tp;
   } side_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DIV_W-1:0] rem;
      logic [NUM_W-1:0] quo;
      logic [DIV_W-1:0] divisor;
   } div_data_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } root_data_type;

endpackage

// ===== sv/rpr_div_cell.sv =====
`timescale 1ns / 1ps
module rpr_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  rpr_pkg::div_data_type in_data,
   input  rpr_pkg::side_type     in_side,
   output logic                  out_valid,
   output rpr_pkg::div_data_type out_data,
   output rpr_pkg::side_type     out_side
);
   import rpr_pkg::*;

   logic                 valid_ff;
   div_data_type         data_ff, data_in;
   side_type             side_ff;
   logic [DIV_W:0]       cur;
   logic [DIV_W:0]       diff;
   logic                 ge;

   // one restoring quotient bit
   always_comb begin
      cur  = {in_data.rem, in_data.num[NUM_W-1]};
      diff = cur - {1'b0, in_data.divisor};
      ge   = (cur >= {1'b0, in_data.divisor});
      data_in.num     = {in_data.num[NUM_W-2:0], 1'b0};
      data_in.rem     = ge ? diff[DIV_W-1:0] : cur[DIV_W-1:0];
      data_in.quo     = {in_data.quo[NUM_W-2:0], ge};
      data_in.divisor = in_data.divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_side  = side_ff;

endmodule

// ===== sv/rpr_root_cell.sv =====
`timescale 1ns / 1ps
module rpr_root_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  rpr_pkg::root_data_type in_data,
   input  rpr_pkg::side_type      in_side,
   output logic                   out_valid,
   output rpr_pkg::root_data_type out_data,
   output rpr_pkg::side_type      out_side
);
   import rpr_pkg::*;

   logic          valid_ff;
   root_data_type data_ff, data_in;
   side_type      side_ff;
   logic [REM_W-1:0] cur;
   logic [REM_W-1:0] trial;
   logic             ge;

   // one root bit: bring down two radicand bits, try (root << 2) | 1
   always_comb begin
      cur   = {in_data.rem[REM_W-3:0], in_data.rad[RAD_W-1:RAD_W-2]};
      trial = {1'b0, in_data.root, 2'b01};
      ge    = (cur >= trial);
      data_in.rad  = {in_data.rad[RAD_W-3:0], 2'b00};
      data_in.rem  = ge ? (cur - trial) : cur;
      data_in.root = {in_data.root[ROOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_side  = side_ff;

endmodule

// ===== sv/reactive_power_requirement_unit.sv =====
`timescale 1ns / 1ps
// Reactive power requirement unit: one result beat per sample beat.
// Registers from accepted sample to result beat: entry stage, 23 divider
// cells, square stage, radicand stage, 23 root cells, output register.
// Throughput: one sample per cycle; the whole chain advances together and halts
// only while a result beat sits stalled in the output register.
// Reset (synchronous, active high) empties the chain and loads register defaults.
module reactive_power_requirement_unit (
   input  logic                            clock,
   input  logic                            reset,
   // sample channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_phase,
   input  logic [rpr_pkg::P_W-1:0]         req_active_power,
   input  logic [rpr_pkg::Q_W-1:0]         req_reactive_power,
   input  logic signed [rpr_pkg::PF_W-1:0] req_power_factor,
   input  logic                            req_hold,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_phase_out,
   output logic                            rsp_updated,
   output logic signed [rpr_pkg::KVAR_W-1:0] rsp_excess_kvar,
   output logic signed [rpr_pkg::KVAR_W-1:0] rsp_required_kvar,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rpr_pkg::ADDR_W-1:0]      csr_paddr,
   input  logic [rpr_pkg::DATA_W-1:0]      csr_pwdata,
   output logic [rpr_pkg::DATA_W-1:0]      csr_prdata,
   output logic                            csr_pready
);
   import rpr_pkg::*;

   localparam int NSTEP = NUM_W;

   // ---------------------------------------------------------------- registers
   logic [SP_W-1:0]  sp_ff;
   logic [THR_W-1:0] thr_ff;
   logic [TP_W-1:0]  tp_ff;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff  <= SP_W'(92);
         thr_ff <= THR_W'(100);
         tp_ff  <= TP_W'(1);
      end else if (wr_en) begin
         case (csr_paddr[3:2])
            REG_PF_SETPOINT: sp_ff  <= csr_pwdata[SP_W-1:0];
            REG_DISCONNECT:  thr_ff <= csr_pwdata[THR_W-1:0];
            REG_TP_RATIO:    tp_ff  <= csr_pwdata[TP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_PF_SETPOINT: csr_prdata = DATA_W'(sp_ff);
         REG_DISCONNECT:  csr_prdata = DATA_W'(thr_ff);
         REG_TP_RATIO:    csr_prdata = DATA_W'(tp_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // -------------------------------------------------------------- flow control
   // Every stage moves on the same enable; hold it only for a stalled result.
   logic advance;
   logic out_valid_ff;

   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // ------------------------------------------------------ entry: classify sample
   logic             cap, band;
   logic [PF_W-1:0]  abs_pf;
   logic [18:0]      pf_prod;
   logic [7:0]       w4, w4e;
   logic [8:0]       band_sum;
   mode_type         mode;
   logic             use_thr;
   logic [DIV_W-1:0] div_raw, div_sel;
   side_type         side_in;
   div_data_type     div_in;

   always_comb begin
      cap     = (req_power_factor > 0);
      band    = (thr_ff >= THR_W'(100));
      abs_pf  = cap ? req_power_factor : PF_W'(-req_power_factor);
      pf_prod = {7'b0, abs_pf} * 19'd100;
      w4      = pf_prod[17:10];
      // full-scale capacitive pf counts as inductive unity in the band
      w4e     = (cap && band) ? 8'd100 : w4;
      band_sum = {1'b0, w4e} + {1'b0, thr_ff};
      use_thr = cap;
      if (req_hold) begin
         mode = MODE_ZERO;
      end else if ((req_reactive_power == '0) && !band) begin
         mode = MODE_ZERO;
      end else if (cap && band && (req_power_factor != PF_W'(1024))) begin
         mode = MODE_DIRECT;
      end else if (cap && !band) begin
         mode = (w4 >= thr_ff) ? MODE_ZERO : MODE_SCALE_EXC;
      end else if (band && ({1'b0, w4e} >= {2'b0, sp_ff})) begin
         // inside the disconnect band no correction; above it report excess
         use_thr = 1'b1;
         mode = (band_sum <= 9'd200) ? MODE_ZERO : MODE_BAND;
      end else begin
         mode = cap ? MODE_SCALE_EXC : MODE_SCALE_REQ;
      end
      div_raw = use_thr ? thr_ff : {1'b0, sp_ff};
      div_sel = (div_raw == '0) ? DIV_W'(1) : div_raw;

      side_in.phase   = req_phase;
      side_in.updated = !req_hold;
      side_in.mode    = mode;
      side_in.p       = req_active_power;
      side_in.q       = req_reactive_power;
      side_in.tp      = tp_ff;

      div_in.num     = NUM_W'(req_active_power) * NUM_W'(100);
      div_in.rem     = '0;
      div_in.quo     = '0;
      div_in.divisor = div_sel;
   end

   logic         s0_valid_ff;
   side_type     s0_side_ff;
   div_data_type s0_div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_side_ff <= side_in;
         s0_div_ff  <= div_in;
      end
   end

   // ------------------------------------------------------ divider cell chain
   logic         dv_valid [0:NSTEP];
   div_data_type dv_data  [0:NSTEP];
   side_type     dv_side  [0:NSTEP];

   assign dv_valid[0] = s0_valid_ff;
   assign dv_data[0]  = s0_div_ff;
   assign dv_side[0]  = s0_side_ff;

   for (genvar i = 0; i < NSTEP; i++) begin : g_div
      rpr_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (dv_valid[i]),
         .in_data   (dv_data[i]),
         .in_side   (dv_side[i]),
         .out_valid (dv_valid[i+1]),
         .out_data  (dv_data[i+1]),
         .out_side  (dv_side[i+1])
      );
   end

   // ------------------------------------------------------------ square stage
   logic             sq_valid_ff;
   side_type         sq_side_ff;
   logic [RAD_W-1:0] a2_ff;
   logic [2*P_W-1:0] b2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_valid_ff <= dv_valid[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_side_ff <= dv_side[NSTEP];
         a2_ff      <= RAD_W'(dv_data[NSTEP].quo) * RAD_W'(dv_data[NSTEP].quo);
         b2_ff      <= (2*P_W)'(dv_side[NSTEP].p) * (2*P_W)'(dv_side[NSTEP].p);
      end
   end

   // ---------------------------------------------------------- radicand stage
   // Clamp a negative radicand to zero.
   logic             rd_valid_ff;
   side_type         rd_side_ff;
   logic [RAD_W-1:0] rad_ff;
   logic [RAD_W-1:0] b2_ext;

   assign b2_ext = RAD_W'(b2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (advance) begin
         rd_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_side_ff <= sq_side_ff;
         rad_ff     <= (a2_ff > b2_ext) ? (a2_ff - b2_ext) : '0;
      end
   end

   // --------------------------------------------------------- root cell chain
   logic          rt_valid [0:NSTEP];
   root_data_type rt_data  [0:NSTEP];
   side_type      rt_side  [0:NSTEP];

   assign rt_valid[0]     = rd_valid_ff;
   assign rt_data[0].rad  = rad_ff;
   assign rt_data[0].rem  = '0;
   assign rt_data[0].root = '0;
   assign rt_side[0]      = rd_side_ff;

   for (genvar i = 0; i < NSTEP; i++) begin : g_root
      rpr_root_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (rt_valid[i]),
         .in_data   (rt_data[i]),
         .in_side   (rt_side[i]),
         .out_valid (rt_valid[i+1]),
         .out_data  (rt_data[i+1]),
         .out_side  (rt_side[i+1])
      );
   end

   // ------------------------------------------------------------ output stage
   side_type          fin_side;
   logic [KVAR_W-1:0] w1, w1_abs;
   logic [KVAR_W+TP_W-1:0] scaled;
   logic [KVAR_W-1:0] exc_in, req_in;

   always_comb begin
      fin_side = rt_side[NSTEP];
      w1       = fin_side.q - rt_data[NSTEP].root[KVAR_W-1:0];
      w1_abs   = w1[KVAR_W-1] ? (~w1 + KVAR_W'(1)) : w1;
      scaled   = {{TP_W{1'b0}}, w1} * {{KVAR_W{1'b0}}, fin_side.tp};
      exc_in   = '0;
      req_in   = '0;
      case (fin_side.mode)
         MODE_ZERO:      ;
         MODE_DIRECT:    exc_in = fin_side.q;
         MODE_BAND:      exc_in = w1_abs;
         MODE_SCALE_EXC: exc_in = scaled[KVAR_W-1:0];
         MODE_SCALE_REQ: req_in = scaled[KVAR_W-1:0];
         default:        ;
      endcase
   end

   logic [1:0]        phase_ff;
   logic              updated_ff;
   logic [KVAR_W-1:0] exc_ff, req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= rt_valid[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         phase_ff   <= fin_side.phase;
         updated_ff <= fin_side.updated;
         exc_ff     <= exc_in;
         req_ff     <= req_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_phase_out     = phase_ff;
   assign rsp_updated       = updated_ff;
   assign rsp_excess_kvar   = exc_ff;
   assign rsp_required_kvar = req_ff;

   // -------------------------------------------------------------- assertions
   a_held_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_updated |-> (rsp_excess_kvar == '0) && (rsp_required_kvar == '0))
      else $error("held beat carries nonzero kvar");

   a_one_sided: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_excess_kvar == '0) || (rsp_required_kvar == '0))
      else $error("excess and required both nonzero");

   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall not tied to stalled result");

   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

endmodule

// ===== tb/tb_reactive_power_requirement_unit.sv =====
`timescale 1ns / 1ps
module tb_reactive_power_requirement_unit;
   import rpr_pkg::*;

   // One sample beat as offered on the request channel.
   typedef struct {
      logic [1:0]             phase;
      logic [P_W-1:0]         p;
      logic [Q_W-1:0]         q;
      logic signed [PF_W-1:0] pf;
      logic                   hold;
   } sample_type;

   // One result beat as seen on the response channel.
   typedef struct {
      logic [1:0]               phase;
      logic                     updated;
      logic [KVAR_W-1:0]        excess;
      logic [KVAR_W-1:0]        required;
   } kvar_type;

   // Scoreboard: keeps its own copy of the register file, predicts the kvar
   // result of each accepted sample and checks result beats in order.
   class kvar_scoreboard;
      int unsigned setpoint = 92;
      int unsigned threshold = 100;
      int unsigned ratio = 1;
      kvar_type pending[$];
      int errors = 0;

      function longint unsigned floor_sqrt(longint unsigned v);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      // Q - isqrt((P*100/div)^2 - P^2), 16-bit wrap
      function logic [15:0] kvar_shortfall(longint unsigned p, longint unsigned q,
                                           longint unsigned dv);
         longint unsigned a, b, rad;
         if (dv == 0) dv = 1;
         a = (p * 100) / dv;
         a = a * a;
         b = p * p;
         rad = (a > b) ? a - b : 0;
         return 16'(q - floor_sqrt(rad));
      endfunction

      function kvar_type predict_kvar(sample_type s);
         kvar_type r;
         int pfv, w4;
         bit cap, band;
         logic [15:0] w1;
         r.phase = s.phase;
         r.updated = !s.hold;
         r.excess = '0;
         r.required = '0;
         pfv = int'(s.pf);
         cap = pfv > 0;
         band = threshold >= 100;
         if (s.hold) return r;
         if (s.q == 0 && !band) return r;
         if (cap && band && pfv != 1024) begin
            // capacitive sample in the inductive band: remove all of Q
            r.excess = s.q;
            return r;
         end
         if (cap && !band) begin
            if ((pfv * 100) / 1024 >= threshold) return r;
         end else begin
            w4 = cap ? 100 : ((-pfv) * 100) / 1024;
            if (w4 >= setpoint && band) begin
               if (w4 <= 200 - int'(threshold)) return r;
               w1 = kvar_shortfall(s.p, s.q, threshold);
               if (w1[15]) w1 = -w1;
               r.excess = w1;
               return r;
            end
         end
         w1 = kvar_shortfall(s.p, s.q, cap ? threshold : setpoint);
         w1 = 16'(w1 * ratio);
         if (cap) r.excess = w1;
         else r.required = w1;
         return r;
      endfunction

      function void note_sample(sample_type s);
         pending.push_back(predict_kvar(s));
      endfunction

      function void check_result(kvar_type got);
         kvar_type exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat phase=%0d", $time, got.phase);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.phase !== exp.phase) begin
            $display("%0t: phase_out exp %0d got %0d", $time, exp.phase, got.phase);
            errors++;
         end
         if (got.updated !== exp.updated) begin
            $display("%0t: updated exp %0d got %0d", $time, exp.updated, got.updated);
            errors++;
         end
         if (got.excess !== exp.excess) begin
            $display("%0t: excess_kvar exp %h got %h", $time, exp.excess, got.excess);
            errors++;
         end
         if (got.required !== exp.required) begin
            $display("%0t: required_kvar exp %h got %h", $time, exp.required,
                     got.required);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_stall;
   logic [1:0] req_phase = '0;
   logic [P_W-1:0] req_active_power = '0;
   logic [Q_W-1:0] req_reactive_power = '0;
   logic signed [PF_W-1:0] req_power_factor = '0;
   logic req_hold = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [1:0] rsp_phase_out;
   logic rsp_updated;
   logic signed [KVAR_W-1:0] rsp_excess_kvar, rsp_required_kvar;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic csr_pready;

   kvar_scoreboard sb = new();

   int send_idle_pct = 0;   // chance in percent that the sender skips a cycle
   int recv_stall_pct = 0;  // chance in percent that the receiver stalls
   bit holdoff_req = 0;     // ask the receiver for one long hold-off
   int quiet_cycles = 0;    // cycles since the last beat on either channel

   reactive_power_requirement_unit DUT (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Receiver: random stall, or a long counted hold-off when asked.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (holdoff_req) begin
            holdoff_req = 0;
            hold_left = 400;
         end
         if (hold_left > 0) hold_left--;
         rsp_stall = (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Check every result beat taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         kvar_type got;
         got.phase = rsp_phase_out;
         got.updated = rsp_updated;
         got.excess = rsp_excess_kvar;
         got.required = rsp_required_kvar;
         sb.check_result(got);
      end
   end

   // Watchdog: end the run if no beat moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 3000) begin
            $display("tb_reactive_power_requirement_unit: FAIL");
            $finish;
         end
      end
   end

   // Offer one sample, idling at random first; hold it until accepted.
   task automatic send_sample(sample_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 0;
      end
      @(negedge clock);
      req_valid = 1;
      req_phase = s.phase;
      req_active_power = s.p;
      req_reactive_power = s.q;
      req_power_factor = s.pf;
      req_hold = s.hold;
      do @(posedge clock); while (req_stall);
      sb.note_sample(s);
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [DATA_W-1:0] val);
      @(negedge clock);
      csr_psel = 1;
      csr_penable = 0;
      csr_pwrite = 1;
      csr_paddr = ADDR_W'(idx * 4);
      csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      case (idx)
         REG_PF_SETPOINT: sb.setpoint = 32'(val[6:0]);
         REG_DISCONNECT:  sb.threshold = 32'(val[7:0]);
         default:         sb.ratio = 32'(val[9:0]);
      endcase
   endtask

   task automatic configure(int sp, int thr, int tp);
      csr_write(REG_PF_SETPOINT, sp);
      csr_write(REG_DISCONNECT, thr);
      csr_write(REG_TP_RATIO, tp);
   endtask

   // Random sample, biased toward legal pf and Q near the correction point.
   function automatic sample_type random_sample();
      sample_type s;
      int r;
      s.phase = 2'($urandom_range(3));
      r = $urandom_range(9);
      s.p = (r < 6) ? 16'($urandom_range(2000)) : 16'($urandom);
      s.q = (r < 3) ? 16'($urandom_range(1500)) : ((r == 9) ? 16'd0 : 16'($urandom));
      r = $urandom_range(19);
      if (r == 0) s.pf = 12'($urandom);
      else if (r == 1) s.pf = 12'(1024);
      else s.pf = 12'(int'($urandom_range(2048)) - 1024);
      s.hold = ($urandom_range(9) == 0);
      return s;
   endfunction

   initial begin : stimulus
      sample_type s;
      int pfs[8];
      int n;
      pfs = '{0, 1024, -1024, 2047, -2048, 1, -1, 941};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: register defaults, then field extremes, hold and phase 3.
      for (int k = 0; k < 8; k++) begin
         s.phase = 2'(k % 4);
         s.p = (k % 2) ? 16'hFFFF : 16'd0;
         s.q = (k % 3 == 0) ? 16'hFFFF : 16'd0;
         s.pf = 12'(pfs[k]);
         s.hold = 0;
         send_sample(s);
      end
      s = '{2'd3, 16'd1000, 16'd500, -12'sd700, 1'b1};
      send_sample(s);
      s = '{2'd2, 16'd1000, 16'd900, -12'sd700, 1'b0};
      send_sample(s);
      drain();

      configure(0, 150, 1023);
      for (int k = 0; k < 8; k++) begin
         s = '{2'(k % 4), 16'd3000, 16'd2000, 12'(pfs[k]), 1'b0};
         send_sample(s);
      end
      drain();

      configure(100, 50, 7);
      for (int k = 0; k < 6; k++) begin
         s = '{2'(k % 4), 16'hFFFF, 16'hFFFF, 12'(pfs[k]), 1'b0};
         send_sample(s);
      end
      drain();

      // Random phases over several register settings and idling mixes.
      for (int ph = 0; ph < 9; ph++) begin
         case (ph % 3)
            0: begin send_idle_pct = 25; recv_stall_pct = 86; end
            1: begin send_idle_pct = 86; recv_stall_pct = 25; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         case (ph)
            0: configure(92, 100, 1);
            1: configure(127, 255, 0);
            2: configure(50, 50, 1000);
            3: configure($urandom_range(50, 100), $urandom_range(100, 150),
                         $urandom_range(1, 1000));
            4: configure($urandom_range(50, 100), $urandom_range(50, 99),
                         $urandom_range(1, 1000));
            5: configure(0, 0, 1023);
            default: configure($urandom_range(127), $urandom_range(255),
                               $urandom_range(1023));
         endcase
         // Long receiver hold-off while samples keep coming: fill the chain.
         if (ph == 2 || ph == 8) holdoff_req = 1;
         n = (ph % 3 == 1) ? 120 : 300;
         repeat (n) send_sample(random_sample());
         // Pause the sender until every expected result has arrived.
         drain();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      if (sb.errors == 0) begin
         $display("tb_reactive_power_requirement_unit: PASS");
      end else begin
         $display("tb_reactive_power_requirement_unit: FAIL");
      end
      $finish;
   end

endmodule
